@@ src/saf_pkg.sv @@
// shared types and constants for the stun attribute finder
package saf_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned TypeW      = 16;
  localparam int unsigned LenW       = 16;
  localparam int unsigned PosW       = 16;
  localparam int unsigned SkipW      = LenW + 1;
  localparam int unsigned AlignBytes = 4;
  localparam int unsigned AlignMask  = 3;

  typedef enum logic [4:0] {
    PhTypeHi = 5'b00001,
    PhTypeLo = 5'b00010,
    PhLenHi  = 5'b00100,
    PhLenLo  = 5'b01000,
    PhSkip   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] attr_offset;
    logic [LenW-1:0] attr_length;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } res_push_t;

endpackage

@@ src/saf_in_if.sv @@
// byte channel into the attribute finder
interface saf_in_if;
  import saf_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_data;
  logic             last_byte;

  modport source (output valid, output byte_data, output last_byte, input ready);
  modport sink (input valid, input byte_data, input last_byte, output ready);
endinterface

@@ src/saf_out_if.sv @@
// result channel out of the attribute finder
interface saf_out_if;
  import saf_pkg::*;

  logic            valid;
  logic            ready;
  logic            found;
  logic [PosW-1:0] attr_offset;
  logic [LenW-1:0] attr_length;

  modport source (output valid, output found, output attr_offset, output attr_length,
                  input ready);
  modport sink (input valid, input found, input attr_offset, input attr_length,
                output ready);
endinterface

@@ src/stun_attribute_finder.sv @@
// top level of the stun attribute finder
// Takes the attribute area of a STUN message one byte per cycle and walks
// its type-length-value attributes, reporting the first one whose type
// equals match_type: the result word, with the header's byte offset and the
// unpadded value length, is registered in the output stage as that header's
// length low byte is taken. An area that ends without a match gives one word
// with found low, registered as its last byte is taken; bytes after a match
// are taken and dropped, and after every last byte the walk starts over. The
// sustained rate is one byte per cycle; in_i.ready falls only while both the
// output register and its one-word skid entry hold words the sink has not
// taken. Write match_type only while no area is in flight.
module stun_attribute_finder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [saf_pkg::TypeW-1:0] cfg_wdata_i,
  saf_in_if.sink                    in_i,
  saf_out_if.source                 out_o
);
  import saf_pkg::*;

  res_push_t res;
  logic      room;
  logic      accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  saf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_data_i (in_i.byte_data),
    .last_byte_i (in_i.last_byte),
    .res_o       (res)
  );

  saf_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

@@ src/saf_parser.sv @@
// tlv walk state and per-byte result logic
module saf_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [saf_pkg::TypeW-1:0]     cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [saf_pkg::ByteW-1:0]     byte_data_i,
  input  logic                          last_byte_i,
  output saf_pkg::res_push_t            res_o
);
  import saf_pkg::*;

  phase_e           phase_q, phase_d;
  logic [TypeW-1:0] type_q, type_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  start_q, start_d;
  logic             done_q, done_d;
  logic [TypeW-1:0] match_q;
  logic [SkipW-1:0] padded;

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    len_d   = len_q;
    skip_d  = skip_q;
    pos_d   = pos_q;
    start_d = start_q;
    done_d  = done_q;
    res_o   = '0;
    padded  = ({1'b0, len_q[LenW-1:ByteW], byte_data_i} + SkipW'(AlignMask))
              & ~SkipW'(AlignBytes - 1);
    if (accept_i) begin
      if (!done_q) begin
        unique case (phase_q)
          PhTypeHi: begin
            start_d = pos_q;
            type_d  = {byte_data_i, {(TypeW-ByteW){1'b0}}};
            phase_d = PhTypeLo;
          end
          PhTypeLo: begin
            type_d  = {type_q[TypeW-1:ByteW], byte_data_i};
            phase_d = PhLenHi;
          end
          PhLenHi: begin
            len_d   = {byte_data_i, {(LenW-ByteW){1'b0}}};
            phase_d = PhLenLo;
          end
          PhLenLo: begin
            len_d = {len_q[LenW-1:ByteW], byte_data_i};
            if (type_q == match_q) begin
              res_o.push             = 1'b1;
              res_o.res.found        = 1'b1;
              res_o.res.attr_offset  = start_q;
              res_o.res.attr_length  = {len_q[LenW-1:ByteW], byte_data_i};
              done_d                 = 1'b1;
            end else begin
              skip_d  = padded;
              phase_d = (padded != '0) ? PhSkip : PhTypeHi;
            end
          end
          PhSkip: begin
            skip_d = (skip_q != '0) ? skip_q - SkipW'(1) : skip_q;
            if (skip_d == '0) begin
              phase_d = PhTypeHi;
            end
          end
          default: phase_d = PhTypeHi;
        endcase
      end
      pos_d = pos_q + PosW'(1);
      if (last_byte_i) begin
        if (!done_d) begin
          res_o.push = 1'b1;
          res_o.res  = '0;
        end
        phase_d = PhTypeHi;
        type_d  = '0;
        len_d   = '0;
        skip_d  = '0;
        pos_d   = '0;
        start_d = '0;
        done_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTypeHi;
      type_q  <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      pos_q   <= '0;
      start_q <= '0;
      done_q  <= 1'b0;
      match_q <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        match_q <= cfg_wdata_i;
      end
    end
  end

  // no result once a match was reported in this area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !res_o.push)
    else $error("result after match");

  // not-found only on the last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.push && !res_o.res.found |-> accept_i && last_byte_i)
    else $error("not-found before last byte");

  // last byte returns walk to start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> pos_q == '0 && phase_q == PhTypeHi && !done_q)
    else $error("state not cleared after last byte");

  // skip phase always has bytes left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSkip |-> skip_q != '0)
    else $error("skip phase with zero count");

endmodule

@@ src/saf_out_stage.sv @@
// output register with skid entry
module saf_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  saf_pkg::res_push_t res_i,
  output logic               room_o,
  saf_out_if.source          out_o
);
  import saf_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic load;

  assign load   = !out_valid_q || out_o.ready;
  assign room_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q  <= skid_valid_q || res_i.push;
      skid_valid_q <= 1'b0;
    end else if (res_i.push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= skid_valid_q ? skid_q : res_i.res;
    end else if (res_i.push) begin
      skid_q <= res_i.res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_q.found;
  assign out_o.attr_offset = out_q.attr_offset;
  assign out_o.attr_length = out_q.attr_length;

  // skid entry only holds a word behind a waiting output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word without output word");

  // no word pushed while skid entry is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.push |-> !skid_valid_q)
    else $error("push into full output stage");

  // a stalled word with skid full keeps the skid full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_o.ready |=> skid_valid_q && out_valid_q)
    else $error("skid word lost under stall");

endmodule
